// ===== hdl/reader_writer_lock_manager_core_defines.svh =====
// Assertion helpers for the lock manager checker
`ifndef READER_WRITER_LOCK_MANAGER_CORE_DEFINES_SVH
`define READER_WRITER_LOCK_MANAGER_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset
`define RWLM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: antecedent leads to consequent in the same cycle
`define RWLM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    `RWLM_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hdl/rwlm_pkg.sv =====
package rwlm_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int COUNT_BITS = 8;
    localparam int ID_W       = 4;
    localparam int TASK_W     = $clog2(NUM_TASKS);
    localparam int QLEN_W     = $clog2(NUM_TASKS + 1);
    localparam int SUM_W      = TASK_W + 1;
    localparam int ID_LIMIT   = (NUM_TASKS < 16) ? NUM_TASKS : 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        CMD_LOCK_READ     = 3'd0,
        CMD_TRY_READ      = 3'd1,
        CMD_RELEASE_READ  = 3'd2,
        CMD_LOCK_WRITE    = 3'd3,
        CMD_TRY_WRITE     = 3'd4,
        CMD_RELEASE_WRITE = 3'd5,
        CMD_DOWNGRADE     = 3'd6,
        CMD_QUERY         = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_WAIT    = 2'd1,
        ST_REFUSED = 2'd2,
        ST_ERROR   = 2'd3
    } t_status;

    typedef enum logic {
        KIND_RESPONSE = 1'b0,
        KIND_GRANT    = 1'b1
    } t_kind;

    typedef enum logic {
        BK_CMD,
        BK_GRANT
    } t_back_state;

    // Classified command as held in the front queue
    typedef struct packed {
        t_cmd            cmd;
        logic            id_ok;
        logic [ID_W-1:0] task_id;
    } t_item;

    typedef struct packed {
        t_kind           kind;
        logic [ID_W-1:0] target_task;
        t_status         status;
        logic            write_locked;
        logic            last;
    } t_result;

endpackage

// ===== hdl/rwlm_if.sv =====
interface rwlm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [3:0] task_id;

    modport source (output valid, output cmd, output task_id, input ready);
    modport sink   (input valid, input cmd, input task_id, output ready);
endinterface

interface rwlm_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [3:0] target_task;
    logic [1:0] status;
    logic       write_locked;
    logic       last;

    modport source (output valid, output kind, output target_task, output status,
                    output write_locked, output last, input ready);
    modport sink   (input valid, input kind, input target_task, input status,
                    input write_locked, input last, output ready);
endinterface

// ===== hdl/reader_writer_lock_manager_core.sv =====
// An accepted command passes the two-entry front queue, then the result register
// of the back part. Each command gives one response beat and up to 15 grant beats
// from the single execute stage and the grant emitter; no new command executes
// while grants are out. Results stall on ready without losing queued commands.
// Reset: synchronous, active low; clears the lock flags, writer queue pointers
// and all handshake state, no clearing pass; read depths and queue slots are not reset.
module reader_writer_lock_manager_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rwlm_cmd_if.sink    i_cmd,
    rwlm_res_if.source  o_res
);

    rwlm_pkg::t_item w_item;
    logic            w_item_valid;
    logic            w_item_pop;

    rwlm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    rwlm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .o_res        (o_res)
    );

endmodule

// ===== hdl/rwlm_front.sv =====
module rwlm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rwlm_cmd_if.sink            i_cmd,
    output rwlm_pkg::t_item     o_item,
    output logic                o_item_valid,
    input  logic                i_item_pop
);

    rwlm_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    rwlm_pkg::t_item w_item;
    logic            w_push;
    logic            w_pop;

    // classify the incoming beat
    always_comb begin
        w_item.cmd     = rwlm_pkg::t_cmd'(i_cmd.cmd);
        w_item.task_id = i_cmd.task_id;
        w_item.id_ok   = (int'(i_cmd.task_id) < rwlm_pkg::ID_LIMIT);
    end

    assign i_cmd.ready  = (r_count != 2'd2);
    assign w_push       = i_cmd.valid && i_cmd.ready;
    assign w_pop        = i_item_pop && (r_count != 2'd0);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];

    // two-entry queue towards the back part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= w_item;
    end

endmodule

// ===== hdl/rwlm_back.sv =====
module rwlm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rwlm_pkg::t_item     i_item,
    input  logic                i_item_valid,
    output logic                o_item_pop,
    rwlm_res_if.source          o_res
);

    localparam int N  = rwlm_pkg::NUM_TASKS;
    localparam int TW = rwlm_pkg::TASK_W;
    localparam int CW = rwlm_pkg::COUNT_BITS;
    localparam int QW = rwlm_pkg::QLEN_W;
    localparam int SW = rwlm_pkg::SUM_W;

    // lock tables
    logic [N-1:0]  r_present, n_present;
    logic [N-1:0]  r_hold, n_hold;
    logic [N-1:0]  r_queued, n_queued;
    logic [CW-1:0] r_depth [N];
    logic [CW-1:0] n_depth [N];
    logic [TW-1:0] r_wq [N];
    logic [TW-1:0] r_head, n_head;
    logic [QW-1:0] r_qlen, n_qlen;
    logic [CW-1:0] r_wdepth, n_wdepth;

    // grant emitter and output register
    rwlm_pkg::t_back_state r_state, n_state;
    logic [N-1:0]          r_mask, n_mask;
    logic                  r_gw, n_gw;
    logic                  r_wl, n_wl;
    rwlm_pkg::t_result     r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  w_out_free;
    logic                  w_go;
    logic [TW-1:0]         w_idx;
    logic [TW-1:0]         w_head_id;
    logic                  w_owner;
    logic                  w_waiting;
    logic [N-1:0]          w_wait_mask;
    logic [N-1:0]          w_onehot;
    logic                  w_push;
    logic [TW-1:0]         w_tail;
    logic [SW-1:0]         w_tail_sum;
    logic [TW-1:0]         w_head_inc;
    logic [CW-1:0]         w_dep_t;
    logic [CW-1:0]         w_dep_dec;
    rwlm_pkg::t_status     w_status;
    logic                  w_has_grant;
    logic [TW-1:0]         w_first;
    logic [N-1:0]          w_mask_rest;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_idx       = TW'(i_item.task_id);
    assign w_head_id   = r_wq[r_head];
    assign w_owner     = (r_qlen != '0) && (w_head_id == w_idx) && (r_wdepth != '0);
    assign w_waiting   = (r_present[w_idx] && !r_hold[w_idx]) || (r_queued[w_idx] && !w_owner);
    assign w_wait_mask = r_present & ~r_hold;
    assign w_onehot    = N'(1) << w_idx;
    assign w_dep_t     = r_depth[w_idx];
    assign w_dep_dec   = w_dep_t - CW'(1);
    assign w_tail_sum  = SW'(r_head) + SW'(r_qlen);
    assign w_tail      = (w_tail_sum >= SW'(N)) ? TW'(w_tail_sum - SW'(N)) : TW'(w_tail_sum);
    assign w_head_inc  = (r_head == TW'(N - 1)) ? '0 : r_head + TW'(1);
    assign w_go        = (r_state == rwlm_pkg::BK_CMD) && i_item_valid && w_out_free;
    assign o_item_pop  = w_go;

    // lowest pending grant
    always_comb begin
        w_first = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_mask[i]) w_first = TW'(i);
        end
    end
    assign w_mask_rest = r_mask & ~(N'(1) << w_first);

    // command execution, grant sequencing and next state
    always_comb begin
        n_present   = r_present;
        n_hold      = r_hold;
        n_queued    = r_queued;
        n_depth     = r_depth;
        n_head      = r_head;
        n_qlen      = r_qlen;
        n_wdepth    = r_wdepth;
        n_state     = r_state;
        n_mask      = r_mask;
        n_gw        = r_gw;
        n_wl        = r_wl;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        w_push      = 1'b0;
        w_status    = rwlm_pkg::ST_DONE;
        w_has_grant = 1'b0;

        unique case (r_state)
            rwlm_pkg::BK_CMD: begin
                if (w_go) begin
                    n_mask = '0;
                    n_gw   = 1'b0;
                    if (!i_item.id_ok) begin
                        w_status = rwlm_pkg::ST_ERROR;
                    end else if (i_item.cmd != rwlm_pkg::CMD_QUERY && w_waiting) begin
                        w_status = rwlm_pkg::ST_ERROR;
                    end else begin
                        unique case (i_item.cmd)
                            rwlm_pkg::CMD_LOCK_READ, rwlm_pkg::CMD_TRY_READ: begin
                                priority if (w_owner) begin
                                    w_status = rwlm_pkg::ST_DONE;
                                end else if (r_present[w_idx]) begin
                                    if (w_dep_t == rwlm_pkg::COUNT_MAX) begin
                                        w_status = rwlm_pkg::ST_ERROR;
                                    end else begin
                                        n_depth[w_idx] = w_dep_t + CW'(1);
                                    end
                                end else if (r_qlen == '0) begin
                                    n_present[w_idx] = 1'b1;
                                    n_hold[w_idx]    = 1'b1;
                                    n_depth[w_idx]   = CW'(1);
                                end else if (i_item.cmd == rwlm_pkg::CMD_LOCK_READ) begin
                                    n_present[w_idx] = 1'b1;
                                    n_depth[w_idx]   = '0;
                                    w_status         = rwlm_pkg::ST_WAIT;
                                end else begin
                                    w_status = rwlm_pkg::ST_REFUSED;
                                end
                            end
                            rwlm_pkg::CMD_RELEASE_READ: begin
                                priority if (w_owner) begin
                                    w_status = rwlm_pkg::ST_DONE;
                                end else if (!r_present[w_idx]) begin
                                    w_status = rwlm_pkg::ST_ERROR;
                                end else begin
                                    n_depth[w_idx] = w_dep_dec;
                                    if (w_dep_dec == '0) begin
                                        n_present[w_idx] = 1'b0;
                                        n_hold[w_idx]    = 1'b0;
                                    end
                                    // last reader out hands over to the queued writer
                                    if (n_hold == '0 && r_qlen != '0 && r_wdepth == '0) begin
                                        n_wdepth    = CW'(1);
                                        n_gw        = 1'b1;
                                        w_has_grant = 1'b1;
                                    end
                                end
                            end
                            rwlm_pkg::CMD_LOCK_WRITE: begin
                                priority if (w_owner) begin
                                    if (r_wdepth == rwlm_pkg::COUNT_MAX) begin
                                        w_status = rwlm_pkg::ST_ERROR;
                                    end else begin
                                        n_wdepth = r_wdepth + CW'(1);
                                    end
                                end else if (r_qlen == '0) begin
                                    w_push = 1'b1;
                                    if (r_present == '0) begin
                                        n_wdepth = CW'(1);
                                    end else begin
                                        n_wdepth = '0;
                                        w_status = rwlm_pkg::ST_WAIT;
                                    end
                                end else begin
                                    w_push   = 1'b1;
                                    w_status = rwlm_pkg::ST_WAIT;
                                end
                            end
                            rwlm_pkg::CMD_TRY_WRITE: begin
                                if (r_qlen == '0 && r_present == '0) begin
                                    w_push   = 1'b1;
                                    n_wdepth = CW'(1);
                                end else begin
                                    w_status = rwlm_pkg::ST_REFUSED;
                                end
                            end
                            rwlm_pkg::CMD_RELEASE_WRITE: begin
                                if (!w_owner) begin
                                    w_status = rwlm_pkg::ST_ERROR;
                                end else begin
                                    n_wdepth = r_wdepth - CW'(1);
                                    if (r_wdepth == CW'(1)) begin
                                        n_head          = w_head_inc;
                                        n_qlen          = r_qlen - QW'(1);
                                        n_queued[w_idx] = 1'b0;
                                        if (r_qlen != QW'(1)) begin
                                            n_wdepth    = CW'(1);
                                            n_gw        = 1'b1;
                                            w_has_grant = 1'b1;
                                        end else begin
                                            n_mask      = w_wait_mask;
                                            n_hold      = r_hold | w_wait_mask;
                                            w_has_grant = (w_wait_mask != '0);
                                            for (int i = 0; i < N; i++) begin
                                                if (w_wait_mask[i]) n_depth[i] = CW'(1);
                                            end
                                        end
                                    end
                                end
                            end
                            rwlm_pkg::CMD_DOWNGRADE: begin
                                if (!w_owner || r_wdepth != CW'(1) || r_present[w_idx]) begin
                                    w_status = rwlm_pkg::ST_ERROR;
                                end else begin
                                    n_head          = w_head_inc;
                                    n_qlen          = r_qlen - QW'(1);
                                    n_queued[w_idx] = 1'b0;
                                    n_wdepth        = '0;
                                    n_mask          = w_wait_mask;
                                    n_present       = r_present | w_onehot;
                                    n_hold          = r_hold | w_wait_mask | w_onehot;
                                    w_has_grant     = (w_wait_mask != '0);
                                    for (int i = 0; i < N; i++) begin
                                        if (w_wait_mask[i] || w_onehot[i]) n_depth[i] = CW'(1);
                                    end
                                end
                            end
                            rwlm_pkg::CMD_QUERY: begin
                                w_status = rwlm_pkg::ST_DONE;
                            end
                            default: begin
                                w_status = rwlm_pkg::ST_DONE;
                            end
                        endcase
                    end
                    if (w_push && r_qlen != QW'(N)) begin
                        n_qlen          = r_qlen + QW'(1);
                        n_queued[w_idx] = 1'b1;
                    end
                    n_wl        = (n_qlen != '0) && (n_wdepth != '0);
                    n_out.kind         = rwlm_pkg::KIND_RESPONSE;
                    n_out.target_task  = i_item.task_id;
                    n_out.status       = w_status;
                    n_out.write_locked = n_wl;
                    n_out.last         = !w_has_grant;
                    n_out_valid        = 1'b1;
                    if (w_has_grant) n_state = rwlm_pkg::BK_GRANT;
                end
            end
            rwlm_pkg::BK_GRANT: begin
                if (w_out_free) begin
                    n_out.kind         = rwlm_pkg::KIND_GRANT;
                    n_out.status       = rwlm_pkg::ST_DONE;
                    n_out.write_locked = r_wl;
                    n_out_valid        = 1'b1;
                    if (r_gw) begin
                        n_out.target_task = rwlm_pkg::ID_W'(w_head_id);
                        n_out.last        = 1'b1;
                        n_gw              = 1'b0;
                        n_state           = rwlm_pkg::BK_CMD;
                    end else begin
                        n_out.target_task = rwlm_pkg::ID_W'(w_first);
                        n_out.last        = (w_mask_rest == '0);
                        n_mask            = w_mask_rest;
                        if (w_mask_rest == '0) n_state = rwlm_pkg::BK_CMD;
                    end
                end
            end
            default: n_state = rwlm_pkg::BK_CMD;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rwlm_pkg::BK_CMD;
            r_present   <= '0;
            r_hold      <= '0;
            r_queued    <= '0;
            r_head      <= '0;
            r_qlen      <= '0;
            r_wdepth    <= '0;
            r_out_valid <= 1'b0;
            r_gw        <= 1'b0;
            r_mask      <= '0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_hold      <= n_hold;
            r_queued    <= n_queued;
            r_head      <= n_head;
            r_qlen      <= n_qlen;
            r_wdepth    <= n_wdepth;
            r_out_valid <= n_out_valid;
            r_gw        <= n_gw;
            r_mask      <= n_mask;
        end
    end

    // payload: counts, writer queue slots, result beat
    always_ff @(posedge i_clk) begin
        r_depth <= n_depth;
        r_wl    <= n_wl;
        r_out   <= n_out;
        if (w_push && r_qlen != QW'(N)) r_wq[w_tail] <= w_idx;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.target_task  = r_out.target_task;
    assign o_res.status       = r_out.status;
    assign o_res.write_locked = r_out.write_locked;
    assign o_res.last         = r_out.last;

endmodule

// ===== hdl/rwlm_checker.sv =====
`include "reader_writer_lock_manager_core_defines.svh"

module rwlm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_kind,
    input logic [3:0] i_target,
    input logic [1:0] i_status,
    input logic       i_wl,
    input logic       i_last
);

    // a stalled result beat keeps its payload
    `RWLM_ASSERT_IMPL(a_hold, i_clk, i_rst_n, i_valid && !i_ready, ##1 (i_valid && $stable({i_kind, i_target, i_status, i_wl, i_last})), "result changed while stalled")

    // grants always report done
    `RWLM_ASSERT_IMPL(a_grant_done, i_clk, i_rst_n, i_valid && i_kind, i_status == 2'd0, "grant with non-done status")

    // wait, refusal and error wake nobody
    `RWLM_ASSERT_IMPL(a_fail_last, i_clk, i_rst_n, i_valid && !i_kind && i_status != 2'd0, i_last, "failed response followed by grants")

endmodule

bind reader_writer_lock_manager_core rwlm_checker u_rwlm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_kind   (o_res.kind),
    .i_target (o_res.target_task),
    .i_status (o_res.status),
    .i_wl     (o_res.write_locked),
    .i_last   (o_res.last)
);

// ===== tb/tb_rwlm_ifs.sv =====
`timescale 1ns / 1ps

// Testbench types; the channel interfaces come from the RTL (rwlm_cmd_if, rwlm_res_if).
package tb_rwlm_types_pkg;

    // One expected result beat
    typedef struct packed {
        rwlm_pkg::t_kind   kind;
        logic [3:0]        target_task;
        rwlm_pkg::t_status status;
        logic              write_locked;
        logic              last;
    } t_beat_exp;

    // Directed stimulus row; chk_resp set where the response is known up front
    typedef struct packed {
        rwlm_pkg::t_cmd    cmd;
        logic [3:0]        task_id;
        logic              chk_resp;
        rwlm_pkg::t_status resp_status;
    } t_row;
endpackage

// ===== tb/tb_reader_writer_lock_manager_core.sv =====
`timescale 1ns / 1ps

module tb_reader_writer_lock_manager_core;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM       = 345;
    localparam int NT             = 16;
    localparam int CW             = rwlm_pkg::COUNT_BITS;

    logic i_clk;
    logic i_rst_n;

    rwlm_cmd_if cmd_ch ();
    rwlm_res_if res_ch ();

    reader_writer_lock_manager_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    // Lock state mirror
    logic          rd_present [NT];
    logic [CW-1:0] rd_depth   [NT];
    logic [3:0]    wq         [NT];
    int unsigned   wq_head;
    int unsigned   wq_len;
    logic [CW-1:0] wr_depth;

    tb_rwlm_types_pkg::t_beat_exp expected_beats[$];
    int        mismatch_count;
    int        idle_cycles;
    bit        no_idle_window;
    bit        hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit owner_is(int t);
        return wq_len > 0 && wq[wq_head] == t && wr_depth != 0;
    endfunction

    function automatic bit queued(int t);
        for (int k = 0; k < wq_len; k++)
            if (wq[(wq_head + k) % NT] == t) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit blocked(int t);
        return (rd_present[t] && rd_depth[t] == 0) || (queued(t) && !owner_is(t));
    endfunction

    function automatic bit readers_hold();
        for (int i = 0; i < NT; i++)
            if (rd_present[i] && rd_depth[i] != 0) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit readers_any();
        for (int i = 0; i < NT; i++)
            if (rd_present[i]) return 1'b1;
        return 1'b0;
    endfunction

    // Lock arbitration: apply one command and queue its result beats
    task automatic arbitrate(input rwlm_pkg::t_cmd c, input int t,
                             output rwlm_pkg::t_status st);
        logic [3:0] woken[$];
        logic       wl;
        tb_rwlm_types_pkg::t_beat_exp b;
        st = rwlm_pkg::ST_DONE;
        if (blocked(t) && c != rwlm_pkg::CMD_QUERY) st = rwlm_pkg::ST_ERROR;
        else begin
            case (c)
                rwlm_pkg::CMD_LOCK_READ, rwlm_pkg::CMD_TRY_READ: begin
                    if (owner_is(t)) st = rwlm_pkg::ST_DONE;
                    else if (rd_present[t]) begin
                        if (rd_depth[t] == rwlm_pkg::COUNT_MAX) st = rwlm_pkg::ST_ERROR;
                        else rd_depth[t]++;
                    end else if (wq_len == 0) begin
                        rd_present[t] = 1'b1;
                        rd_depth[t] = CW'(1);
                    end else if (c == rwlm_pkg::CMD_LOCK_READ) begin
                        rd_present[t] = 1'b1;
                        rd_depth[t] = '0;
                        st = rwlm_pkg::ST_WAIT;
                    end else st = rwlm_pkg::ST_REFUSED;
                end
                rwlm_pkg::CMD_RELEASE_READ: begin
                    if (owner_is(t)) st = rwlm_pkg::ST_DONE;
                    else if (!rd_present[t]) st = rwlm_pkg::ST_ERROR;
                    else begin
                        rd_depth[t]--;
                        if (rd_depth[t] == 0) rd_present[t] = 1'b0;
                        if (!readers_hold() && wq_len > 0 && wr_depth == 0) begin
                            wr_depth = CW'(1);
                            woken.push_back(wq[wq_head]);
                        end
                    end
                end
                rwlm_pkg::CMD_LOCK_WRITE: begin
                    if (owner_is(t)) begin
                        if (wr_depth == rwlm_pkg::COUNT_MAX) st = rwlm_pkg::ST_ERROR;
                        else wr_depth++;
                    end else begin
                        if (wq_len == 0) begin
                            if (!readers_any()) wr_depth = CW'(1);
                            else begin
                                wr_depth = '0;
                                st = rwlm_pkg::ST_WAIT;
                            end
                        end else st = rwlm_pkg::ST_WAIT;
                        if (wq_len < NT) begin
                            wq[(wq_head + wq_len) % NT] = 4'(t);
                            wq_len++;
                        end
                    end
                end
                rwlm_pkg::CMD_TRY_WRITE: begin
                    if (wq_len == 0 && !readers_any()) begin
                        wq[wq_head] = 4'(t);
                        wq_len = 1;
                        wr_depth = CW'(1);
                    end else st = rwlm_pkg::ST_REFUSED;
                end
                rwlm_pkg::CMD_RELEASE_WRITE: begin
                    if (!owner_is(t)) st = rwlm_pkg::ST_ERROR;
                    else begin
                        wr_depth--;
                        if (wr_depth == 0) begin
                            wq_head = (wq_head + 1) % NT;
                            wq_len--;
                            if (wq_len > 0) begin
                                wr_depth = CW'(1);
                                woken.push_back(wq[wq_head]);
                            end else begin
                                for (int i = 0; i < NT; i++)
                                    if (rd_present[i] && rd_depth[i] == 0) begin
                                        rd_depth[i] = CW'(1);
                                        woken.push_back(4'(i));
                                    end
                            end
                        end
                    end
                end
                rwlm_pkg::CMD_DOWNGRADE: begin
                    if (!owner_is(t) || wr_depth != 1 || rd_present[t]) st = rwlm_pkg::ST_ERROR;
                    else begin
                        wq_head = (wq_head + 1) % NT;
                        wq_len--;
                        wr_depth = '0;
                        rd_present[t] = 1'b1;
                        rd_depth[t] = CW'(1);
                        for (int i = 0; i < NT; i++)
                            if (rd_present[i] && rd_depth[i] == 0) begin
                                rd_depth[i] = CW'(1);
                                woken.push_back(4'(i));
                            end
                    end
                end
                default: st = rwlm_pkg::ST_DONE;
            endcase
        end
        wl = (wq_len > 0 && wr_depth != 0);
        b.kind = rwlm_pkg::KIND_RESPONSE;
        b.target_task = 4'(t);
        b.status = st;
        b.write_locked = wl;
        b.last = (woken.size() == 0);
        expected_beats.push_back(b);
        foreach (woken[k]) begin
            b.kind = rwlm_pkg::KIND_GRANT;
            b.target_task = woken[k];
            b.status = rwlm_pkg::ST_DONE;
            b.last = (k == woken.size() - 1);
            expected_beats.push_back(b);
        end
    endtask

    // Directed table: every command and the error paths
    tb_rwlm_types_pkg::t_row directed[] = '{
        '{rwlm_pkg::CMD_QUERY,         4'd0,  1'b1, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_RELEASE_READ,  4'd15, 1'b1, rwlm_pkg::ST_ERROR},
        '{rwlm_pkg::CMD_RELEASE_WRITE, 4'd3,  1'b1, rwlm_pkg::ST_ERROR},
        '{rwlm_pkg::CMD_DOWNGRADE,     4'd3,  1'b1, rwlm_pkg::ST_ERROR},
        '{rwlm_pkg::CMD_LOCK_READ,     4'd1,  1'b1, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_TRY_READ,      4'd1,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_TRY_WRITE,     4'd2,  1'b1, rwlm_pkg::ST_REFUSED},
        '{rwlm_pkg::CMD_LOCK_WRITE,    4'd2,  1'b1, rwlm_pkg::ST_WAIT},
        '{rwlm_pkg::CMD_LOCK_READ,     4'd5,  1'b1, rwlm_pkg::ST_WAIT},
        '{rwlm_pkg::CMD_TRY_READ,      4'd6,  1'b1, rwlm_pkg::ST_REFUSED},
        '{rwlm_pkg::CMD_QUERY,         4'd5,  1'b1, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_LOCK_READ,     4'd2,  1'b1, rwlm_pkg::ST_ERROR},
        '{rwlm_pkg::CMD_RELEASE_READ,  4'd1,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_RELEASE_READ,  4'd1,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_LOCK_WRITE,    4'd2,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_LOCK_READ,     4'd2,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_RELEASE_READ,  4'd2,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_TRY_WRITE,     4'd2,  1'b1, rwlm_pkg::ST_REFUSED},
        '{rwlm_pkg::CMD_DOWNGRADE,     4'd2,  1'b1, rwlm_pkg::ST_ERROR},
        '{rwlm_pkg::CMD_RELEASE_WRITE, 4'd2,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_DOWNGRADE,     4'd2,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_RELEASE_READ,  4'd2,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_RELEASE_READ,  4'd5,  1'b0, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_TRY_WRITE,     4'd15, 1'b1, rwlm_pkg::ST_DONE},
        '{rwlm_pkg::CMD_RELEASE_WRITE, 4'd15, 1'b0, rwlm_pkg::ST_DONE}
    };

    // Offer one beat and wait for acceptance; prediction happens at acceptance
    task automatic send_cmd(input rwlm_pkg::t_cmd c, input logic [3:0] t,
                            output rwlm_pkg::t_status st);
        while (!no_idle_window && $urandom_range(99) < 16) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.cmd     <= c;
        cmd_ch.task_id <= t;
        do @(posedge i_clk); while (!cmd_ch.ready);
        arbitrate(c, int'(t), st);
        @(negedge i_clk);
    endtask

    // Random command biased towards well-formed lock sequences
    task automatic send_random();
        rwlm_pkg::t_cmd    c;
        rwlm_pkg::t_status st;
        logic [3:0]        t;
        int                r;
        r = $urandom_range(99);
        t = $urandom_range(3) == 0 ? 4'($urandom) : 4'($urandom_range(5));
        if (r < 8 && wq_len > 0 && wr_depth != 0) begin
            t = wq[wq_head];
            c = $urandom_range(1) ? rwlm_pkg::CMD_RELEASE_WRITE : rwlm_pkg::CMD_DOWNGRADE;
        end else if (r < 30) begin
            for (int i = 0; i < NT; i++)
                if (rd_present[i] && rd_depth[i] != 0 && $urandom_range(1)) t = 4'(i);
            c = rwlm_pkg::CMD_RELEASE_READ;
        end else c = rwlm_pkg::t_cmd'($urandom_range(7));
        send_cmd(c, t, st);
    endtask

    // Response-side readiness with random idling and one long hold-off
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            res_ch.ready <= !hold_off && (no_idle_window || $urandom_range(99) >= 16);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        tb_rwlm_types_pkg::t_beat_exp e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_beats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result beat for task %0d",
                                                   res_ch.target_task);
            end else begin
                e = expected_beats.pop_front();
                if (res_ch.kind !== e.kind || res_ch.target_task !== e.target_task ||
                    res_ch.status !== e.status || res_ch.write_locked !== e.write_locked ||
                    res_ch.last !== e.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"beat mismatch: exp k%0d t%0d s%0d w%0d l%0d ",
                                  "got k%0d t%0d s%0d w%0d l%0d"},
                                 e.kind, e.target_task, e.status, e.write_locked, e.last,
                                 res_ch.kind, res_ch.target_task, res_ch.status,
                                 res_ch.write_locked, res_ch.last);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("reader_writer_lock_manager_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int                settle;
        rwlm_pkg::t_status st;
        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = rwlm_pkg::CMD_QUERY;
        cmd_ch.task_id   = '0;
        mismatch_count   = 0;
        idle_cycles      = 0;
        no_idle_window   = 1'b0;
        hold_off         = 1'b0;
        for (int i = 0; i < NT; i++) begin
            rd_present[i] = 1'b0;
            rd_depth[i]   = '0;
            wq[i]         = '0;
        end
        wq_head  = 0;
        wq_len   = 0;
        wr_depth = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // typed response status checked where the row carries one
        foreach (directed[k]) begin
            send_cmd(directed[k].cmd, directed[k].task_id, st);
            if (directed[k].chk_resp && st != directed[k].resp_status) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("directed row %0d: exp status %0d, predicted %0d",
                             k, directed[k].resp_status, st);
            end
        end

        // Long receiver hold-off while commands keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 30; k++) send_random();
        join

        for (int k = 0; k < N_RANDOM; k++) begin
            no_idle_window = (k >= 100 && k < 180);
            send_random();
        end
        no_idle_window = 1'b0;
        cmd_ch.valid <= 1'b0;

        settle = 0;
        while (expected_beats.size() != 0 && settle < 20000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("reader_writer_lock_manager_core: match");
        else
            $display("reader_writer_lock_manager_core: mismatch");
        $finish;
    end
endmodule
